// ----- hdl/usig_pkg.sv -----
// ----------------------------------------------------------------------------
// usig_pkg
// Shared types and constants for the UV sphere triangle index generator.
// ----------------------------------------------------------------------------
`default_nettype none

package usig_pkg;

	localparam int IDX_W   = 16;
	localparam int RING_W  = 8;
	localparam int MER_W   = RING_W + 1;
	localparam int POS_W   = 10;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [RING_W-1:0] RING_RESET = 8'd8;
	localparam logic [RING_W-1:0] RING_MIN   = 8'd2;

	// register select is the word address bit
	localparam logic REG_RING_COUNT = 1'b0;
	localparam logic REG_CLOCKWISE  = 1'b1;

	typedef enum logic [2:0] {
		SEC_TOP    = 3'b001,
		SEC_BAND   = 3'b010,
		SEC_BOTTOM = 3'b100
	} section_t;

endpackage

`default_nettype wire

// ----- hdl/uv_sphere_index_generator.sv -----
// ----------------------------------------------------------------------------
// uv_sphere_index_generator
// Emits the triangle index list of a UV sphere, one triangle per beat:
// top cap fan, latitude bands, bottom cap fan.
// ----------------------------------------------------------------------------
// An accepted input beat passes through the input register, then the output register, to its result beat.
// Throughput: one triangle per cycle while the result side does not stall; counters update in a single pass.
// A full output register held by result_stall stalls the input register behind it.
// Reset: ring_count = 8, clockwise_front = 0, sequence at the first triangle.
// ----------------------------------------------------------------------------
`default_nettype none

module uv_sphere_index_generator
	import usig_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,

	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,

	input  wire logic               item_valid,
	output logic                    item_stall,
	input  wire logic               restart,

	output logic                    result_valid,
	input  wire logic               result_stall,
	output logic      [IDX_W-1:0]   index_a,
	output logic      [IDX_W-1:0]   index_b,
	output logic      [IDX_W-1:0]   index_c,
	output logic                    last_triangle
);

	logic [RING_W-1:0] ring_q;
	logic              cw_q;

	section_t          sec_q;
	logic [RING_W-1:0] band_q;
	logic [POS_W-1:0]  pos_q;
	logic [IDX_W-1:0]  offs_q;
	logic              half_q;

	logic              valid_s1;
	logic              restart_s1;

	logic              out_free;
	logic              advance;

	// config port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_q <= RING_RESET;
			cw_q   <= 1'b0;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				REG_RING_COUNT: ring_q <= pwdata[RING_W-1:0];
				REG_CLOCKWISE:  cw_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_RING_COUNT: prdata = {{(PDATA_W-RING_W){1'b0}}, ring_q};
			REG_CLOCKWISE:  prdata = {{(PDATA_W-1){1'b0}}, cw_q};
			default:        prdata = '0;
		endcase
	end

	// handshake
	assign out_free   = !result_valid || !result_stall;
	assign advance    = valid_s1 && out_free;
	assign item_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (!item_stall)
				valid_s1 <= item_valid;
			if (out_free)
				result_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall)
			restart_s1 <= restart;
	end

	// index computation
	logic [RING_W-1:0] r;
	logic [MER_W-1:0]  m;
	logic [POS_W-1:0]  m_m1;
	logic [IDX_W-1:0]  m16;

	section_t          sec_e;
	logic [RING_W-1:0] band_e;
	logic [POS_W-1:0]  pos_e;
	logic [IDX_W-1:0]  offs_e;
	logic              half_e;
	logic              at_end;

	logic [IDX_W-1:0]  p16;
	logic [IDX_W-1:0]  i16;
	logic [IDX_W-1:0]  pole;
	logic [RING_W-1:0] band_inc;

	logic [IDX_W-1:0]  a_n, b_n, c_n;
	logic              last_n;

	section_t          sec_n;
	logic [RING_W-1:0] band_n;
	logic [POS_W-1:0]  pos_n;
	logic [IDX_W-1:0]  offs_n;
	logic              half_n;

	assign r    = (ring_q < RING_MIN) ? RING_MIN : ring_q;
	assign m    = {r, 1'b0};
	assign m_m1 = POS_W'(m) - POS_W'(1);
	assign m16  = IDX_W'(m);

	always_comb begin
		if (restart_s1) begin
			sec_e  = SEC_TOP;
			band_e = '0;
			pos_e  = '0;
			offs_e = IDX_W'(1);
			half_e = 1'b0;
		end else begin
			sec_e  = sec_q;
			band_e = band_q;
			pos_e  = pos_q;
			offs_e = offs_q;
			half_e = half_q;
		end
	end

	assign at_end   = (pos_e >= m_m1);
	assign p16      = IDX_W'(pos_e);
	assign i16      = offs_e + p16;
	assign pole     = offs_e + m16;
	assign band_inc = band_e + RING_W'(1);

	always_comb begin
		sec_n  = sec_e;
		band_n = band_e;
		pos_n  = pos_e + POS_W'(1);
		offs_n = offs_e;
		half_n = half_e;
		last_n = 1'b0;
		case (sec_e)
			SEC_TOP: begin
				a_n = '0;
				if (at_end) begin
					b_n    = m16;
					c_n    = IDX_W'(1);
					offs_n = IDX_W'(1);
					band_n = '0;
					half_n = 1'b0;
					pos_n  = '0;
					sec_n  = (r > RING_MIN) ? SEC_BAND : SEC_BOTTOM;
				end else begin
					b_n = p16 + IDX_W'(1);
					c_n = p16 + IDX_W'(2);
				end
			end
			SEC_BAND: begin
				a_n = i16;
				if (!half_e) begin
					b_n    = i16 + m16;
					c_n    = at_end ? i16 + IDX_W'(1) : i16 + m16 + IDX_W'(1);
					half_n = 1'b1;
					pos_n  = pos_e;
				end else begin
					b_n    = at_end ? i16 + IDX_W'(1) : i16 + m16 + IDX_W'(1);
					c_n    = at_end ? offs_e : i16 + IDX_W'(1);
					half_n = 1'b0;
					if (at_end) begin
						pos_n  = '0;
						offs_n = offs_e + m16;
						band_n = band_inc;
						if (band_inc >= r - RING_MIN)
							sec_n = SEC_BOTTOM;
					end
				end
			end
			default: begin
				a_n = pole;
				if (at_end) begin
					b_n    = offs_e;
					c_n    = pole - IDX_W'(1);
					last_n = 1'b1;
					sec_n  = SEC_TOP;
					band_n = '0;
					pos_n  = '0;
					offs_n = IDX_W'(1);
					half_n = 1'b0;
				end else begin
					b_n = i16 + IDX_W'(1);
					c_n = i16;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q  <= SEC_TOP;
			band_q <= '0;
			pos_q  <= '0;
			offs_q <= IDX_W'(1);
			half_q <= 1'b0;
		end else if (advance) begin
			sec_q  <= sec_n;
			band_q <= band_n;
			pos_q  <= pos_n;
			offs_q <= offs_n;
			half_q <= half_n;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			index_a       <= a_n;
			index_b       <= cw_q ? c_n : b_n;
			index_c       <= cw_q ? b_n : c_n;
			last_triangle <= last_n;
		end
	end

	// checks
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid && result_stall)
		else $error("input stalled with output register free");

	a_top_clean: assert property (@(posedge clk) disable iff (!arst_n)
		sec_q == SEC_TOP |-> offs_q == IDX_W'(1) && !half_q)
		else $error("top cap entered with stale band state");

	a_half_in_band: assert property (@(posedge clk) disable iff (!arst_n)
		sec_q != SEC_BAND |-> !half_q)
		else $error("quad half flag set outside bands");

	a_s1_drains: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !result_valid |=> result_valid)
		else $error("input register did not move to output register");

endmodule

`default_nettype wire

// ----- sim/uv_sphere_checker.sv -----
// ----------------------------------------------------------------------------
// uv_sphere_checker
// Watches the register port and both beat channels of the UV sphere index
// generator, predicts every triangle from its own copy of the sequence
// counters and register values, and compares each result beat field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module uv_sphere_checker
	import usig_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,

	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	input  wire logic [PDATA_W-1:0] prdata,
	input  wire logic               pready,

	input  wire logic               item_valid,
	input  wire logic               item_stall,
	input  wire logic               restart,

	input  wire logic               result_valid,
	input  wire logic               result_stall,
	input  wire logic [IDX_W-1:0]   index_a,
	input  wire logic [IDX_W-1:0]   index_b,
	input  wire logic [IDX_W-1:0]   index_c,
	input  wire logic               last_triangle,

	output int                      mismatches,
	output int                      outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [IDX_W-1:0] a;
		logic [IDX_W-1:0] b;
		logic [IDX_W-1:0] c;
		logic             last;
	} triangle_t;

	logic [RING_W-1:0] ring_cfg   = RING_RESET;
	logic              cw_cfg     = 1'b0;
	section_t          part       = SEC_TOP;
	logic [7:0]        band_num   = '0;
	logic [POS_W-1:0]  pos        = '0;
	logic [IDX_W-1:0]  band_off   = IDX_W'(1);
	logic              upper_half = 1'b0;

	triangle_t pending_tris[$];

	initial mismatches = 0;
	initial outstanding = 0;

	function automatic void rewind_mesh();
		part       = SEC_TOP;
		band_num   = '0;
		pos        = '0;
		band_off   = IDX_W'(1);
		upper_half = 1'b0;
	endfunction

	function automatic triangle_t next_triangle(input logic rs);
		int unsigned r, m, p, i, pole, a, b, c, tmp;
		logic        at_end;
		triangle_t   t;
		r      = (ring_cfg < RING_MIN) ? 2 : ring_cfg;
		m      = 2 * r;
		p      = pos;
		at_end = (p >= m - 1);
		t.last = 1'b0;
		if (rs) begin
			rewind_mesh();
			p      = 0;
			at_end = 1'b0;
		end
		case (part)
			SEC_TOP: begin
				a = 0;
				if (at_end) begin
					b          = m;
					c          = 1;
					band_off   = IDX_W'(1);
					band_num   = '0;
					upper_half = 1'b0;
					pos        = '0;
					part       = (r > 2) ? SEC_BAND : SEC_BOTTOM;
				end else begin
					b   = p + 1;
					c   = p + 2;
					pos = POS_W'(p + 1);
				end
			end
			SEC_BAND: begin
				i = band_off + p;
				a = i;
				if (!upper_half) begin
					b          = i + m;
					c          = at_end ? i + 1 : i + m + 1;
					upper_half = 1'b1;
				end else begin
					b          = at_end ? i + 1 : i + m + 1;
					c          = at_end ? band_off : i + 1;
					upper_half = 1'b0;
					if (at_end) begin
						pos      = '0;
						band_off = IDX_W'(band_off + m);
						band_num = band_num + 8'd1;
						if (band_num >= r - 2)
							part = SEC_BOTTOM;
					end else begin
						pos = POS_W'(p + 1);
					end
				end
			end
			default: begin
				pole = band_off + m;
				a    = pole;
				if (at_end) begin
					b      = band_off;
					c      = pole - 1;
					t.last = 1'b1;
					rewind_mesh();
				end else begin
					b   = band_off + p + 1;
					c   = band_off + p;
					pos = POS_W'(p + 1);
				end
			end
		endcase
		if (cw_cfg) begin
			tmp = b;
			b   = c;
			c   = tmp;
		end
		t.a = a[IDX_W-1:0];
		t.b = b[IDX_W-1:0];
		t.c = c[IDX_W-1:0];
		return t;
	endfunction

	function automatic void check_field(input string name, input logic [PDATA_W-1:0] exp_v,
			input logic [PDATA_W-1:0] act_v);
		if (exp_v !== act_v) begin
			mismatches++;
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		triangle_t want;
		logic [PDATA_W-1:0] reg_val;
		if (!arst_n) begin
			ring_cfg = RING_RESET;
			cw_cfg   = 1'b0;
			rewind_mesh();
			pending_tris.delete();
		end else begin
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr[2] == REG_CLOCKWISE)
						cw_cfg = pwdata[0];
					else
						ring_cfg = pwdata[RING_W-1:0];
				end else begin
					reg_val = (paddr[2] == REG_CLOCKWISE) ? PDATA_W'(cw_cfg) : PDATA_W'(ring_cfg);
					check_field("prdata", reg_val, prdata);
				end
			end
			if (item_valid && !item_stall)
				pending_tris = {pending_tris, next_triangle(restart)};
			if (result_valid && !result_stall) begin
				if (pending_tris.size() == 0) begin
					mismatches++;
					$error("result beat with no triangle expected");
				end else begin
					want = pending_tris.pop_front();
					check_field("index_a", want.a, index_a);
					check_field("index_b", want.b, index_b);
					check_field("index_c", want.c, index_c);
					check_field("last_triangle", want.last, last_triangle);
				end
			end
		end
		outstanding = pending_tris.size();
	end

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the UV sphere index generator: short directed
// meshes at the ring count extremes, one complete mesh across several bands,
// then randomized phases over several register settings
// with random gaps on the request side and stalls on the result side.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import usig_pkg::*;

	localparam int DEEP_RING = 10;
	localparam int PHASES    = 10;
	localparam int PHASE_LEN = 135;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               item_valid;
	logic               item_stall;
	logic               restart;
	logic               result_valid;
	logic               result_stall = 1'b0;
	logic [IDX_W-1:0]   index_a;
	logic [IDX_W-1:0]   index_b;
	logic [IDX_W-1:0]   index_c;
	logic               last_triangle;

	int mismatches;
	int outstanding;
	int gap_pct    = 0;
	int stall_pct  = 0;
	int n_items    = 0;
	int n_results  = 0;
	int n_meshes   = 0;
	int n_settings = 0;

	uv_sphere_index_generator dut (.*);
	uv_sphere_checker checker_i (.*);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	initial begin
		#2ms;
		$display("Verification failed");
		$finish;
	end

	always @(posedge clk) begin
		result_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
		if (arst_n && result_valid && !result_stall) begin
			n_results <= n_results + 1;
			if (last_triangle)
				n_meshes <= n_meshes + 1;
		end
	end

	task automatic send_request(input logic rs);
		while ($urandom_range(99) < gap_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		restart    <= rs;
		n_items++;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
	endtask

	task automatic settle();
		item_valid <= 1'b0;
		while (n_results != n_items)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic reg_write(input logic sel, input logic [PDATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		// read back
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_regs(input int ring, input logic cw);
		settle();
		reg_write(REG_RING_COUNT, PDATA_W'(ring));
		reg_write(REG_CLOCKWISE, PDATA_W'(cw));
		@(posedge clk);
		n_settings++;
	endtask

	initial begin
		int ring_plan [PHASES];
		int ring;
		arst_n     = 1'b0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		item_valid = 1'b0;
		restart    = 1'b0;
		ring_plan  = '{3, 2, 181, 5, 0, 4, 255, 1, 0, 0};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, then a ring count below two: whole mesh plus start-over
		repeat (2) send_request(1'b0);
		set_regs(1, 1'b1);
		send_request(1'b1);
		repeat (16) send_request(1'b0);
		set_regs(255, 1'b0);
		send_request(1'b1);
		repeat (2) send_request(1'b0);

		// one complete mesh through every band
		set_regs(DEEP_RING, 1'($urandom_range(1)));
		send_request(1'b1);
		repeat (4 * DEEP_RING * (DEEP_RING - 1) - 1) send_request(1'b0);

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == PHASES - 2)
				ring = $urandom_range(12, 2);
			else if (ph == PHASES - 1)
				ring = $urandom_range(255);
			else
				ring = ring_plan[ph];
			set_regs(ring, 1'(ph % 2));
			case (ph % 4)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 52; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 52; end
				default: begin gap_pct = 22; stall_pct = 22; end
			endcase
			repeat (PHASE_LEN) send_request($urandom_range(99) < 3);
		end

		settle();
		gap_pct   = 0;
		stall_pct = 0;
		repeat (4) @(posedge clk);
		if (outstanding != 0)
			$error("%0d triangles never came out", outstanding);
		$display("Run covered %0d triangle requests under %0d register settings, %0d meshes closed",
			n_items, n_settings, n_meshes);
		if (mismatches == 0 && outstanding == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire
